// ----- sv/efba_pkg.sv -----
// Shared types and constants for the exact-fit block allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package efba_pkg;

  localparam int unsigned DEFAULT_TABLE_ENTRIES = 64;
  localparam logic [31:0] BASE_ADDRESS_RESET    = 32'h0010_0000;

  // Request kinds carried on the input tuser bit.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Register index decoded from the configuration address.
  localparam logic REG_BASE_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOMEM     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } efba_status_t;

  // One row of the block table.
  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic        busy;
  } efba_entry_t;

endpackage

// ----- sv/exact_fit_block_allocator_top.sv -----
// Top level of the exact-fit block allocator: request sequencer, APB register,
// result register. Instantiates efba_mem and efba_alu; uses efba_pkg.
`timescale 1ns / 1ps

// The allocator keeps a table of address blocks (start, end, in-use) sorted by
// start address from high to low, with used rows packed at the front; a fill
// count marks how many rows are in use, so reset needs no clearing pass and
// the table is usable in the cycle after reset. One request is handled at a
// time and in_tready is low while it runs. Every request first reads the used
// rows once through the single table read port, one row per cycle. A free, a
// reuse of an exact fit, or a refusal on a full table ends after this scan; an
// address overflow is refused in the alignment step or the end check.
// Placing a new block adds an alignment step, an end check, a downward shift
// pass over the rows below the insertion point (again one row per cycle) and
// the write of the new row. The next request can be taken in the cycle after
// the result is loaded. All address arithmetic goes through one shared 33-bit
// adder. Each request produces exactly one result transfer with the block
// address (0 on a free or a failure) and a status: ok, out of memory or
// address overflow, or free address not found. The result waits in an output
// register, and the next request is taken while it waits. base_address is
// written over APB at byte address 0; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module exact_fit_block_allocator_top #(
  parameter int unsigned TABLE_ENTRIES = efba_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // size[31:0], align_mask[63:32], address[95:64]
  input  logic         in_tuser,   // action[0]: 0 allocate, 1 free
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // block_address[31:0], status[33:32], zero[39:34]
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import efba_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALIGN,
    S_ENDCHK,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

  state_t       state_r, state_nxt;
  logic [31:0]  base_r, base_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic         rd_pend_r, rd_pend_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;

  logic         act_r, act_nxt;
  logic [31:0]  size_r, size_nxt;
  logic [31:0]  mask_r, mask_nxt;
  logic [31:0]  addr_r, addr_nxt;
  logic [31:0]  from_r, from_nxt;

  logic         fit_found_r, fit_found_nxt;
  logic [IW-1:0] fit_idx_r, fit_idx_nxt;
  logic [31:0]  fit_start_r, fit_start_nxt;
  logic [31:0]  fit_end_r, fit_end_nxt;
  logic         found_r, found_nxt;

  logic [31:0]  new_start_r, new_start_nxt;
  logic [31:0]  new_end_r, new_end_nxt;
  logic         stop_r, stop_nxt;
  logic [IW-1:0] pos_r, pos_nxt;

  logic [31:0]  res_addr_r, res_addr_nxt;
  efba_status_t res_status_r, res_status_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_addr_r, out_addr_nxt;
  efba_status_t out_status_r, out_status_nxt;

  // table port and shared adder
  logic         mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  efba_entry_t  mem_wdata, rd_data;
  logic [31:0]  alu_a, alu_b;
  logic         alu_cin;
  logic [32:0]  alu_sum;

  // alignment, scan and shift helper terms, APB write strobe
  logic [31:0]  clash, low;
  logic         issue, ge, hit_stop, cfg_wr;
  logic [CW-1:0] idx_dec;

  efba_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  efba_alu u_alu (
    .op_a     (alu_a),
    .op_b     (alu_b),
    .carry_in (alu_cin),
    .sum      (alu_sum)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_addr_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BASE_ADDRESS) ? base_r : 32'd0;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Smear the highest clashing bit downward for the round-up.
  always_comb begin
    clash = from_r & mask_r;
    low   = clash;
    low   = low | (low >> 1);
    low   = low | (low >> 2);
    low   = low | (low >> 4);
    low   = low | (low >> 8);
    low   = low | (low >> 16);
  end

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    act_nxt        = act_r;
    size_nxt       = size_r;
    mask_nxt       = mask_r;
    addr_nxt       = addr_r;
    from_nxt       = from_r;
    fit_found_nxt  = fit_found_r;
    fit_idx_nxt    = fit_idx_r;
    fit_start_nxt  = fit_start_r;
    fit_end_nxt    = fit_end_r;
    found_nxt      = found_r;
    new_start_nxt  = new_start_r;
    new_end_nxt    = new_end_r;
    stop_nxt       = stop_r;
    pos_nxt        = pos_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;

    mem_we    = 1'b0;
    mem_waddr = rd_idx_r;
    mem_wdata = rd_data;
    mem_re    = 1'b0;
    mem_raddr = idx_r[IW-1:0];
    alu_a     = 32'd0;
    alu_b     = 32'd0;
    alu_cin   = 1'b0;
    issue     = 1'b0;
    ge        = 1'b0;
    hit_stop  = 1'b0;
    idx_dec   = idx_r - 1'b1;

    if (cfg_wr && (cfg_paddr[2] == REG_BASE_ADDRESS)) begin
      base_nxt = cfg_pwdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt       = in_tuser;
          size_nxt      = in_tdata[31:0];
          mask_nxt      = in_tdata[63:32];
          addr_nxt      = in_tdata[95:64];
          from_nxt      = base_r;
          fit_found_nxt = 1'b0;
          found_nxt     = 1'b0;
          idx_nxt       = '0;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        // size of the row in flight: end - start
        alu_a   = rd_data.end_addr;
        alu_b   = ~rd_data.start_addr;
        alu_cin = 1'b1;
        issue   = (idx_r < cnt_r);
        if (issue) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_r[IW-1:0];
          idx_nxt     = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = idx_r[IW-1:0];
        end
        if (rd_pend_r) begin
          if (act_r == ACT_ALLOC) begin
            if (rd_idx_r == '0) begin
              from_nxt = rd_data.end_addr;
            end
            // later hits have lower addresses and win
            if (!rd_data.busy && (alu_sum[31:0] == size_r) &&
                ((rd_data.start_addr & mask_r) == 32'd0)) begin
              fit_found_nxt = 1'b1;
              fit_idx_nxt   = rd_idx_r;
              fit_start_nxt = rd_data.start_addr;
              fit_end_nxt   = rd_data.end_addr;
            end
          end else if (rd_data.start_addr == addr_r) begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_r;
            mem_wdata = '{start_addr: rd_data.start_addr,
                          end_addr:   rd_data.end_addr,
                          busy:       1'b0};
            found_nxt = 1'b1;
          end
        end
        if (!issue && !rd_pend_r) begin
          if (act_r == ACT_FREE) begin
            res_addr_nxt   = 32'd0;
            res_status_nxt = found_r ? ST_OK : ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end else if (fit_found_r) begin
            mem_we         = 1'b1;
            mem_waddr      = fit_idx_r;
            mem_wdata      = '{start_addr: fit_start_r, end_addr: fit_end_r, busy: 1'b1};
            res_addr_nxt   = fit_start_r;
            res_status_nxt = ST_OK;
            state_nxt      = S_DONE;
          end else if (cnt_r == CW'(TABLE_ENTRIES)) begin
            res_addr_nxt   = 32'd0;
            res_status_nxt = ST_NOMEM;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_ALIGN;
          end
        end
      end

      S_ALIGN: begin
        // round up past the clashing bits: (h | m | low) + 1, then clear m
        alu_a   = from_r | mask_r | low;
        alu_cin = 1'b1;
        if (clash == 32'd0) begin
          new_start_nxt = from_r;
          state_nxt     = S_ENDCHK;
        end else if (alu_sum[32]) begin
          res_addr_nxt   = 32'd0;
          res_status_nxt = ST_NOMEM;
          state_nxt      = S_DONE;
        end else begin
          new_start_nxt = alu_sum[31:0] & ~mask_r;
          state_nxt     = S_ENDCHK;
        end
      end

      S_ENDCHK: begin
        alu_a = new_start_r;
        alu_b = size_r;
        if ((new_start_r == 32'd0) || alu_sum[32]) begin
          res_addr_nxt   = 32'd0;
          res_status_nxt = ST_NOMEM;
          state_nxt      = S_DONE;
        end else begin
          new_end_nxt = alu_sum[31:0];
          idx_nxt     = cnt_r;
          stop_nxt    = 1'b0;
          pos_nxt     = '0;
          state_nxt   = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // walk up from the last used row, moving rows that start below the
        // new block down by one; stop at the first row at or above it
        alu_a    = rd_data.start_addr;
        alu_b    = ~new_start_r;
        alu_cin  = 1'b1;
        ge       = alu_sum[32];
        hit_stop = rd_pend_r && !stop_r && ge;
        issue    = (idx_r != '0) && !stop_r && !hit_stop;
        if (issue) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_dec[IW-1:0];
          idx_nxt     = idx_dec;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = idx_dec[IW-1:0];
        end
        if (rd_pend_r && !stop_r) begin
          if (ge) begin
            stop_nxt = 1'b1;
            pos_nxt  = rd_idx_r + 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_r + 1'b1;
            mem_wdata = rd_data;
          end
        end
        if (!issue && !rd_pend_r) begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        mem_we         = 1'b1;
        mem_waddr      = pos_r;
        mem_wdata      = '{start_addr: new_start_r, end_addr: new_end_r, busy: 1'b1};
        cnt_nxt        = cnt_r + 1'b1;
        res_addr_nxt   = new_start_r;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_ADDRESS_RESET;
      cnt_r       <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      fit_found_r <= 1'b0;
      found_r     <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      fit_found_r <= fit_found_nxt;
      found_r     <= found_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    act_r        <= act_nxt;
    size_r       <= size_nxt;
    mask_r       <= mask_nxt;
    addr_r       <= addr_nxt;
    from_r       <= from_nxt;
    fit_idx_r    <= fit_idx_nxt;
    fit_start_r  <= fit_start_nxt;
    fit_end_r    <= fit_end_nxt;
    new_start_r  <= new_start_nxt;
    new_end_r    <= new_end_nxt;
    pos_r        <= pos_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // The fill count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_ENTRIES))
    else $error("block table fill count exceeds depth");

  // Placing a block grows the table by exactly one row.
  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("placement did not advance fill count");

  // The table is never written while no request is in progress.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("table write while idle");

  // A request transfer drops in_tready in the cycle after it.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while another is in progress");

endmodule

// ----- sv/efba_alu.sv -----
// Shared 33-bit adder of the allocator: size compare, alignment round-up,
// end computation and ordering compare all run through it. Uses efba_pkg.
`timescale 1ns / 1ps

module efba_alu (
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  input  logic        carry_in,
  output logic [32:0] sum
);
  import efba_pkg::*;

  assign sum = {1'b0, op_a} + {1'b0, op_b} + {32'd0, carry_in};

endmodule

// ----- sv/efba_mem.sv -----
// Block table storage: one write port, one registered read port.
// Uses efba_pkg for the entry type.
`timescale 1ns / 1ps

module efba_mem #(
  parameter int unsigned DEPTH = efba_pkg::DEFAULT_TABLE_ENTRIES,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  efba_pkg::efba_entry_t wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output efba_pkg::efba_entry_t rdata
);
  import efba_pkg::*;

  efba_entry_t mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule

// ----- dv/efba_result_checker.sv -----
// Result checker for the exact-fit block allocator: watches the request,
// result and APB channels, predicts each result, compares field by field.
// Depends on efba_pkg for status codes and the register index.
`timescale 1ns / 1ps

module efba_result_checker #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,    // size[31:0], align_mask[63:32], address[95:64]
  input  logic        in_tuser,    // action[0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,   // block_address[31:0], status[33:32], zero[39:34]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          n_compared,
  output int          n_granted,
  output int          n_refused,
  output int          n_unknown_free
);
  import efba_pkg::*;

  typedef struct {
    logic [31:0]  block_address;
    efba_status_t status;
  } alloc_reply_t;

  logic [31:0]  blk_start [TABLE_ENTRIES];
  logic [31:0]  blk_end   [TABLE_ENTRIES];
  logic         blk_busy  [TABLE_ENTRIES];
  logic [31:0]  base_addr;
  alloc_reply_t owed_replies[$];
  int           errs, compared, granted, refused, unknown_free;

  // Smallest value not below lo_bound with no mask bit set; 0 when it would
  // need a 33rd bit.
  function automatic bit align_up(input logic [31:0] lo_bound, input logic [31:0] mask,
                                  output logic [31:0] start);
    logic [31:0] clash, low;
    logic [32:0] sum;
    clash = lo_bound & mask;
    start = lo_bound;
    if (clash == '0) return 1'b1;
    low = clash;
    low = low | (low >> 1);
    low = low | (low >> 2);
    low = low | (low >> 4);
    low = low | (low >> 8);
    low = low | (low >> 16);
    sum = {1'b0, lo_bound | mask | low} + 33'd1;
    start = sum[31:0] & ~mask;
    return !sum[32];
  endfunction

  task automatic place_or_reuse(input logic [31:0] size, input logic [31:0] mask,
                                output alloc_reply_t reply);
    int          fit, pos, i;
    logic [31:0] span, lo_bound, start;
    logic [32:0] new_end;
    fit = -1;
    reply.block_address = '0;
    reply.status = ST_NOMEM;
    // the last hit is the lowest-addressed free block of that size
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      span = blk_end[i] - blk_start[i];
      if (blk_start[i] != '0 && !blk_busy[i] && span == size && (blk_start[i] & mask) == '0)
        fit = i;
    end
    if (fit >= 0) begin
      blk_busy[fit] = 1'b1;
      reply.block_address = blk_start[fit];
      reply.status = ST_OK;
    end else if (blk_start[TABLE_ENTRIES-1] == '0) begin
      lo_bound = (blk_start[0] != '0) ? blk_end[0] : base_addr;
      if (align_up(lo_bound, mask, start)) begin
        new_end = {1'b0, start} + {1'b0, size};
        if (start != '0 && !new_end[32]) begin
          pos = 0;
          while (pos < TABLE_ENTRIES-1 && blk_start[pos] != '0 && blk_start[pos] >= start)
            pos++;
          for (i = TABLE_ENTRIES-1; i > pos; i--) begin
            blk_start[i] = blk_start[i-1];
            blk_end[i]   = blk_end[i-1];
            blk_busy[i]  = blk_busy[i-1];
          end
          blk_start[pos] = start;
          blk_end[pos]   = new_end[31:0];
          blk_busy[pos]  = 1'b1;
          reply.block_address = start;
          reply.status = ST_OK;
        end
      end
    end
  endtask

  task automatic release_block(input logic [31:0] address, output alloc_reply_t reply);
    int i;
    reply.block_address = '0;
    reply.status = ST_NOT_FOUND;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (blk_start[i] != '0 && blk_start[i] == address) begin
        blk_busy[i] = 1'b0;
        reply.status = ST_OK;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_reply_t reply, owed;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        blk_start[i] = '0;
        blk_end[i]   = '0;
        blk_busy[i]  = 1'b0;
      end
      base_addr = BASE_ADDRESS_RESET;
      owed_replies.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_BASE_ADDRESS)
        base_addr = cfg_pwdata;
      if (out_tvalid && out_tready) begin
        if (owed_replies.size() == 0) begin
          $error("result 0x%010h arrived with no request outstanding", out_tdata);
          errs++;
        end else begin
          owed = owed_replies.pop_front();
          compared++;
          if (out_tdata[31:0] !== owed.block_address) begin
            $error("block_address: expected 0x%08h, got 0x%08h",
                   owed.block_address, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[33:32] !== owed.status) begin
            $error("status: expected %0d, got %0d", owed.status, out_tdata[33:32]);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_ALLOC)
          place_or_reuse(in_tdata[31:0], in_tdata[63:32], reply);
        else
          release_block(in_tdata[95:64], reply);
        case (reply.status)
          ST_OK:        granted++;
          ST_NOMEM:     refused++;
          default:      unknown_free++;
        endcase
        owed_replies.push_back(reply);
      end
    end
    fail_count     <= errs;
    pending        <= owed_replies.size();
    n_compared     <= compared;
    n_granted      <= granted;
    n_refused      <= refused;
    n_unknown_free <= unknown_free;
  end

endmodule

// ----- dv/exact_fit_block_allocator_top_test.sv -----
// Testbench top for the exact-fit block allocator: clock, reset, request,
// result and APB stimulus, verdict. Uses efba_pkg and efba_result_checker.
`timescale 1ns / 1ps

module exact_fit_block_allocator_top_test;
  import efba_pkg::*;

  localparam int unsigned N_ENTRIES = 64;
  localparam int          RANDOM_REQUESTS = 1430;
  localparam int          HOLD_OFF_CYCLES = 600;
  localparam int          TAIL_CYCLES = 2 * N_ENTRIES + 16;
  // watchdog limit, set well above the slowest run
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0]  CFG_ADDR_BASE  = {REG_BASE_ADDRESS, 2'b00};
  localparam logic [2:0]  CFG_ADDR_SPARE = 3'd4;   // no register behind it

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;     // size[31:0], align_mask[63:32], address[95:64]
  logic        in_tuser = ACT_ALLOC;  // action[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // block_address[31:0], status[33:32], zero[39:34]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count, pending, n_compared, n_granted, n_refused, n_unknown_free;
  int requests_sent = 0;
  int base_writes = 0;

  // Shared knobs between the sender and the receiver.
  logic no_idle = 1'b0;        // suppress all gaps for a stretch
  logic hold_off_req = 1'b0;   // ask the receiver for one long stall

  // Start addresses handed out so far; frees draw from here.
  logic [31:0] granted_addrs[$];

  always #5 clk = ~clk;

  exact_fit_block_allocator_top #(.TABLE_ENTRIES(N_ENTRIES)) u_top (.*);

  efba_result_checker #(.TABLE_ENTRIES(N_ENTRIES)) u_checker (.*);

  // Mostly back-to-back, often a short gap, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sizes and masks from a small pool, so exact fits keep turning up.
  function automatic logic [31:0] pool_size(input int k);
    case (k)
      0:       return 32'h0000_0010;
      1:       return 32'h0000_0020;
      2:       return 32'h0000_0040;
      3:       return 32'h0000_0100;
      4:       return 32'h0000_0000;
      5:       return 32'h0000_1000;
      6:       return 32'h0000_0030;
      default: return 32'h0000_0008;
    endcase
  endfunction

  function automatic logic [31:0] pool_mask(input int k);
    case (k)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_000F;
      2:       return 32'h0000_00FF;
      3:       return 32'h0000_003F;
      4:       return 32'h0000_0001;
      default: return 32'h0000_0FFF;
    endcase
  endfunction

  // Learn granted addresses from the result channel.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tdata[33:32] == ST_OK &&
        out_tdata[31:0] != '0) begin
      granted_addrs.push_back(out_tdata[31:0]);
      if (granted_addrs.size() > 96) void'(granted_addrs.pop_front());
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
    end
  end

  // Offer one request and hold it until the transfer; leave tvalid high when
  // no gap follows so the next request goes out back to back.
  task automatic send_request(input logic act, input logic [31:0] sz,
                              input logic [31:0] mk, input logic [31:0] ad);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {ad, mk, sz};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop tvalid and wait until every result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Setup phase, access phase until pready, then the bus returns to idle.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    base_writes++;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: pooled allocations and frees of granted
  // blocks; the rest is odd sizes, wild masks and frees of unknown addresses.
  task automatic make_random_request(input int n, output logic act, output logic [31:0] sz,
                                     output logic [31:0] mk, output logic [31:0] ad);
    int pick;
    pick = $urandom_range(0, 99);
    act = ACT_ALLOC;
    sz  = $urandom;
    mk  = $urandom;
    ad  = $urandom;
    if (pick < 52) begin
      sz = pool_size($urandom_range(0, 7));
      mk = pool_mask($urandom_range(0, 5));
    end else if (pick < 58) begin
      // keep the address space open until the table has filled
      if (n < 150) begin
        sz = $urandom_range(0, 4095);
        mk = mk & 32'h0000_03FF;
      end
    end else if (pick < 90) begin
      act = ACT_FREE;
      if (granted_addrs.size() > 0)
        ad = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
    end else begin
      act = ACT_FREE;
      if (pick < 93) ad = '0;
      else if (pick < 96 && granted_addrs.size() > 0) ad = granted_addrs[0] + 32'd1;
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d results outstanding", cycles, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic        act;
    logic [31:0] sz, mk, ad;
    int          n, leftover;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, base written as zero: a new block would start at 0.
    write_reg(CFG_ADDR_SPARE, 32'hFFFF_FFFF);
    write_reg(CFG_ADDR_BASE, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'h0000_0010, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_FREE,  32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_drained();

    // Base at the very top: end overflow and alignment overflow.
    write_reg(CFG_ADDR_BASE, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    wait_drained();
    write_reg(CFG_ADDR_BASE, 32'hFFFF_FFF0);
    send_request(ACT_ALLOC, 32'h0000_0010, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'h0000_0000, 32'h0000_0010, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Odd base so the first placement must round up to the mask.
    write_reg(CFG_ADDR_BASE, 32'h0000_1001);
    send_request(ACT_ALLOC, 32'h0000_0100, 32'h0000_0FFF, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'h0000_0100, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'h0000_0100, 32'h0000_0000, 32'h0000_0000);
    // two zero-size blocks sharing one start address
    send_request(ACT_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_FREE,  32'h0000_0000, 32'h0000_0000, 32'h0000_2300);
    send_request(ACT_FREE,  32'h0000_0000, 32'h0000_0000, 32'h0000_2100);
    send_request(ACT_FREE,  32'h0000_0000, 32'h0000_0000, 32'h0000_2000);
    // freeing an already free block still succeeds
    send_request(ACT_FREE,  32'h0000_0000, 32'h0000_0000, 32'h0000_2000);
    // two free exact fits: the lower one wins
    send_request(ACT_ALLOC, 32'h0000_0100, 32'h0000_0000, 32'h0000_0000);
    // free fit exists but is misaligned: place a new block instead
    send_request(ACT_ALLOC, 32'h0000_0100, 32'h0000_01FF, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'h0000_0004, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_FREE,  32'h0000_0000, 32'h0000_0000, 32'hDEAD_BEEF);
    send_request(ACT_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    wait_drained();
    // base no longer matters once blocks exist; write it anyway
    write_reg(CFG_ADDR_BASE, BASE_ADDRESS_RESET);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      // long receiver hold-off with the sender pushing flat out
      if (n == 250) begin
        no_idle = 1'b1;
        hold_off_req <= 1'b1;
      end
      if (n == 420) no_idle = 1'b0;
      if (n == RANDOM_REQUESTS / 2) begin
        wait_drained();
        write_reg(CFG_ADDR_BASE, $urandom);
        write_reg(CFG_ADDR_SPARE, $urandom);
      end
      make_random_request(n, act, sz, mk, ad);
      send_request(act, sz, mk, ad);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    leftover = pending;
    if (leftover != 0) $error("%0d results never arrived", leftover);

    $display("%0d requests, %0d results compared: %0d granted or freed, %0d refused,",
             requests_sent, n_compared, n_granted, n_refused);
    $display("%0d frees of unknown addresses, %0d register writes",
             n_unknown_free, base_writes);
    if (fail_count == 0 && leftover == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
